[hdl/tcw_pkg.sv]
// shared types and constants of the text console writer
package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CODE_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = CODE_W + ATTR_W;

  localparam logic [ATTR_W-1:0] FILL_ATTR_RESET = 8'h07;

  localparam logic [CODE_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_RETURN  = 8'd13;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_FILL_ATTR = 1'b0;

  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_TAB,
    CLS_READ
  } item_class_t;

  typedef struct packed {
    item_class_t         cls;
    logic [CODE_W-1:0]   code;
    logic [ATTR_W-1:0]   attr;
    logic [INDEX_W-1:0]  index;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_head_t;

endpackage

[hdl/tcw_front.sv]
// front end: takes input items, decodes them and pushes them into the queue
module tcw_front import tcw_pkg::*; (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [ATTR_W-1:0]  char_attr,
  input  logic [INDEX_W-1:0] cell_index,
  input  logic               queue_full,
  input  logic               clearing,
  output logic               push,
  output queue_item_t        push_item
);

  item_class_t cls;

  always_comb begin
    if (command == CMD_READ) begin
      cls = CLS_READ;
    end else begin
      case (char_code)
        CHAR_NEWLINE: cls = CLS_NEWLINE;
        CHAR_RETURN:  cls = CLS_RETURN;
        CHAR_TAB:     cls = CLS_TAB;
        default:      cls = CLS_PRINT;
      endcase
    end
  end

  // nothing enters while the cell store is being cleared after reset
  assign in_stall = queue_full || clearing;
  assign push     = in_valid && !in_stall;

  assign push_item.cls   = cls;
  assign push_item.code  = char_code;
  assign push_item.attr  = char_attr;
  assign push_item.index = cell_index;

endmodule

[hdl/tcw_queue.sv]
// short queue of decoded items between front end and back end
module tcw_queue import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/tcw_back.sv]
// back end: cell store, cursor tracking, scroll engine and result register
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ATTR_W-1:0]   fill_attr,
  input  queue_head_t         head,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CURSOR_W-1:0] cursor,
  output logic [CODE_W-1:0]   read_char,
  output logic [ATTR_W-1:0]   read_attr,
  output logic                scrolled
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CUR_W      = $clog2(CELL_COUNT);
  localparam int LIN_W      = $clog2(CELL_COUNT + COLUMNS + TAB_WIDTH);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS + TAB_WIDTH);
  localparam int ROW_W      = $clog2(ROWS + 3);
  localparam int RW         = $clog2(2 * TAB_WIDTH);
  localparam int STEP_W     = $clog2(TAB_WIDTH + 1);
  localparam int PROD_W     = 2 * CUR_W + 1;
  // floor(2^CUR_W / TAB_WIDTH): quotient estimate is exact or one low
  localparam logic [CUR_W:0] RECIP = (CUR_W + 1)'((64'd1 << CUR_W) / TAB_WIDTH);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_READ    = 8'b0000_0100,
    ST_TAB_ADJ = 8'b0000_1000,
    ST_NORM    = 8'b0001_0000,
    ST_CHECK   = 8'b0010_0000,
    ST_COPY    = 8'b0100_0000,
    ST_FILL    = 8'b1000_0000
  } back_state_t;

  back_state_t        state;
  logic [LIN_W-1:0]   lin;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [CNT_W-1:0]   src;
  logic [CUR_W-1:0]   wcnt;
  logic               copy_pend;
  logic [PROD_W-1:0]  prod;
  logic [CELL_W-1:0]  rd_data;

  logic [CELL_W-1:0]  cells [CELL_COUNT];

  logic               take;
  logic               in_range;
  logic               res_load;
  logic               mem_re;
  logic [CUR_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [CUR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;

  logic [CUR_W:0]     q0;
  logic [CUR_W:0]     qt;
  logic [RW-1:0]      r0;
  logic [RW-1:0]      rem;
  logic [STEP_W-1:0]  step;

  assign take     = (state == ST_IDLE) && head.valid && (!out_valid || !out_stall);
  assign pop      = take;
  assign clearing = (state == ST_CLEAR);
  assign in_range = (32'(head.item.index) < CELL_COUNT);

  // a new result enters the result register this cycle
  assign res_load = (take && head.item.cls == CLS_READ && !in_range) ||
                    (state == ST_READ) ||
                    (state == ST_CHECK && row < ROW_W'(ROWS)) ||
                    (state == ST_FILL && wcnt == CUR_W'(CELL_COUNT - 1));

  // tab: remainder of the cursor by the tab width from the registered product
  always_comb begin
    q0   = prod[PROD_W-1:CUR_W];
    qt   = (CUR_W + 1)'(q0 * TAB_WIDTH);
    r0   = RW'((CUR_W + 1)'(lin) - qt);
    rem  = (32'(r0) >= TAB_WIDTH) ? RW'(32'(r0) - TAB_WIDTH) : r0;
    step = STEP_W'(TAB_WIDTH - 32'(rem));
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = wcnt;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (take && head.item.cls == CLS_READ && in_range) begin
          mem_re    = 1'b1;
          mem_raddr = CUR_W'(head.item.index);
        end
        if (take && head.item.cls == CLS_PRINT) begin
          mem_we    = 1'b1;
          mem_waddr = lin[CUR_W-1:0];
          mem_wdata = {head.item.attr, head.item.code};
        end
      end
      ST_COPY: begin
        // read one row ahead, write back the cell read in the cycle before
        if (32'(src) < CELL_COUNT) begin
          mem_re    = 1'b1;
          mem_raddr = src[CUR_W-1:0];
        end
        if (copy_pend) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {fill_attr, CODE_W'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= cells[mem_raddr];
    end
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      lin       <= '0;
      col       <= '0;
      row       <= '0;
      src       <= '0;
      wcnt      <= '0;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_load || (out_valid && out_stall);
      case (state)
        ST_CLEAR: begin
          if (wcnt == CUR_W'(CELL_COUNT - 1)) begin
            wcnt  <= '0;
            state <= ST_IDLE;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (take) begin
            case (head.item.cls)
              CLS_READ: begin
                if (in_range) begin
                  state <= ST_READ;
                end else begin
                  cursor    <= CURSOR_W'(lin);
                  read_char <= '0;
                  read_attr <= '0;
                  scrolled  <= 1'b0;
                end
              end
              CLS_PRINT: begin
                lin   <= lin + 1'b1;
                col   <= col + 1'b1;
                state <= ST_NORM;
              end
              CLS_NEWLINE: begin
                lin   <= lin - LIN_W'(col) + LIN_W'(COLUMNS);
                col   <= '0;
                row   <= row + 1'b1;
                state <= ST_CHECK;
              end
              CLS_RETURN: begin
                lin   <= lin - LIN_W'(col);
                col   <= '0;
                state <= ST_CHECK;
              end
              CLS_TAB: begin
                prod  <= PROD_W'(lin[CUR_W-1:0]) * PROD_W'(RECIP);
                state <= ST_TAB_ADJ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          cursor    <= CURSOR_W'(lin);
          read_char <= rd_data[CODE_W-1:0];
          read_attr <= rd_data[CELL_W-1:CODE_W];
          scrolled  <= 1'b0;
          state     <= ST_IDLE;
        end
        ST_TAB_ADJ: begin
          lin   <= lin + LIN_W'(step);
          col   <= col + COL_W'(step);
          state <= ST_NORM;
        end
        ST_NORM: begin
          // a tab wider than the row may wrap more than once
          if (col >= COL_W'(COLUMNS)) begin
            col <= col - COL_W'(COLUMNS);
            row <= row + 1'b1;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (row >= ROW_W'(ROWS)) begin
            if (row > ROW_W'(ROWS)) begin
              // still past the end after one row: park on the last cell
              lin <= LIN_W'(CELL_COUNT - 1);
              row <= ROW_W'(ROWS - 1);
              col <= COL_W'(COLUMNS - 1);
            end else begin
              lin <= lin - LIN_W'(COLUMNS);
              row <= row - 1'b1;
            end
            src       <= CNT_W'(COLUMNS);
            wcnt      <= '0;
            copy_pend <= 1'b0;
            state     <= ST_COPY;
          end else begin
            cursor    <= CURSOR_W'(lin);
            read_char <= '0;
            read_attr <= '0;
            scrolled  <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_COPY: begin
          if (32'(src) < CELL_COUNT) begin
            src       <= src + 1'b1;
            copy_pend <= 1'b1;
          end else begin
            copy_pend <= 1'b0;
            state     <= ST_FILL;
          end
          if (copy_pend) begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_FILL: begin
          if (wcnt == CUR_W'(CELL_COUNT - 1)) begin
            wcnt      <= '0;
            cursor    <= CURSOR_W'(lin);
            read_char <= '0;
            read_attr <= '0;
            scrolled  <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/text_console_writer.sv]
// top level of the text console writer: register port, front end, queue, back end
//
// Text console with a COLUMNS x ROWS store of 16-bit cells (attribute in the high
// byte) and a linear cursor. Input items are decoded and queued, so up to two
// items are taken while the back end is busy or a result waits on out_stall.
// After reset the back end clears the store, one cell a cycle, and holds in_stall
// high meanwhile. A tab takes its remainder by the tab width from a reciprocal
// multiply; a printable character or a tab then wraps once for each row crossed.
// A put that runs off the end of the screen adds a scroll: the cell memory moves
// one cell a cycle, then writes the bottom row with fill_attr.
// fill_attr lives at address 0 of the register port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [CODE_W-1:0]   char_code,
  input  logic [ATTR_W-1:0]   char_attr,
  input  logic [INDEX_W-1:0]  cell_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CURSOR_W-1:0] cursor,
  output logic [CODE_W-1:0]   read_char,
  output logic [ATTR_W-1:0]   read_attr,
  output logic                scrolled
);

  logic [ATTR_W-1:0] fill_attr;
  logic              queue_full;
  logic              clearing;
  logic              push;
  queue_item_t       push_item;
  logic              pop;
  queue_head_t       head;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_FILL_ATTR) ? 32'(fill_attr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attr <= FILL_ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_FILL_ATTR) begin
      fill_attr <= pwdata[ATTR_W-1:0];
    end
  end

  tcw_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .char_code  (char_code),
    .char_attr  (char_attr),
    .cell_index (cell_index),
    .queue_full (queue_full),
    .clearing   (clearing),
    .push       (push),
    .push_item  (push_item)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  tcw_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fill_attr (fill_attr),
    .head      (head),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cursor    (cursor),
    .read_char (read_char),
    .read_attr (read_attr),
    .scrolled  (scrolled)
  );

endmodule
